### rtl/draw_call_batcher_defines.svh
// assertion macros used by the slot table module
`ifndef DRAW_CALL_BATCHER_DEFINES_SVH
`define DRAW_CALL_BATCHER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DCB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DCB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dcb_pkg.sv
package dcb_pkg;

	// default depth of the texture slot table
	localparam int TEXTURE_SLOTS_DEF = 16;

	typedef struct packed {
		logic [15:0] shader_id;
		logic [3:0]  blend_mode;
		logic [31:0] texture_handle;
		logic        uniforms_dirty;
		logic [31:0] base_index;
		logic [31:0] index_count;
	} sub_t;

	typedef struct packed {
		logic        new_batch;
		logic [15:0] batch_number;
		logic [3:0]  texture_slot;
		logic [31:0] batch_index_offset;
		logic [31:0] batch_index_total;
	} res_t;

	// slot table status toward the batch control
	typedef struct packed {
		logic done;
		logic found;
		logic full;
	} scan_stat_t;

	// batch control decision toward the slot table
	typedef struct packed {
		logic valid;
		logic clear;
	} commit_t;

endpackage

### rtl/draw_call_batcher.sv
// channel | dir | payload           | handshake
// sub     | in  | dcb_pkg::sub_t    | sub_valid, sub_stall (driven here)
// res     | out | dcb_pkg::res_t    | res_valid, res_stall (driven by sink)
//
// one submission at a time; from acceptance to result a transaction waits on
// the slot scan, which reads one handle a cycle from the slot memory, at most
// slots_used handles (slots_used is the fill of the open batch's table), and
// on the result register; the next transaction can be taken in the cycle
// after the result is loaded
// reset is asynchronous active low; it empties the batch state, no clearing
// pass since slot entries are only read below the fill count
// sub_stall is high from acceptance until the result is loaded; a new
// transaction is taken while an earlier result still waits on res_stall
module draw_call_batcher #(
	parameter int TEXTURE_SLOTS = dcb_pkg::TEXTURE_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sub_valid,
	output logic          sub_stall,
	input  dcb_pkg::sub_t sub_data,
	output logic          res_valid,
	input  logic          res_stall,
	output dcb_pkg::res_t res_data
);

	import dcb_pkg::*;

	localparam int SW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;

	// one-hot sequencer states
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t        state_q;
	sub_t          sub_q;
	res_t          res_q;
	logic          res_valid_q;

	// open batch record
	logic          open_q;
	logic [15:0]   shader_q;
	logic [3:0]    blend_q;
	logic [31:0]   offset_q;
	logic [31:0]   total_q;
	logic [15:0]   counter_q;

	logic          accept;
	logic          can_load;
	logic          start;
	logic [31:0]   total_d;
	logic [31:0]   offset_d;
	logic [15:0]   counter_d;
	scan_stat_t    stat;
	commit_t       commit;
	logic [SW-1:0] slot;

	// a transaction is taken only while the sequencer is idle
	assign sub_stall = (state_q != ST_IDLE);
	assign accept    = sub_valid && !sub_stall;

	// result register frees up when empty or being taken this cycle
	assign can_load = !res_valid_q || !res_stall;

	// new batch when none is open, the render state changes, uniforms are
	// dirty, or the texture is absent from a full slot table
	assign start = !open_q
		|| (sub_q.shader_id != shader_q)
		|| (sub_q.blend_mode != blend_q)
		|| sub_q.uniforms_dirty
		|| (!stat.found && stat.full);

	assign total_d   = (start ? 32'd0 : total_q) + sub_q.index_count;
	assign offset_d  = start ? sub_q.base_index : offset_q;
	assign counter_d = (start && open_q) ? counter_q + 16'd1 : counter_q;

	assign commit.valid = (state_q == ST_DECIDE) && can_load;
	assign commit.clear = start;

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	dcb_slot_table #(
		.TEXTURE_SLOTS(TEXTURE_SLOTS)
	) u_slots (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (accept),
		.handle(sub_q.texture_handle),
		.commit(commit),
		.stat  (stat),
		.slot  (slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			open_q      <= 1'b0;
			shader_q    <= '0;
			blend_q     <= '0;
			offset_q    <= '0;
			total_q     <= '0;
			counter_q   <= '0;
		end else begin
			if (commit.valid) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// wait for the slot table search to settle
					if (stat.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (can_load) begin
						state_q   <= ST_IDLE;
						open_q    <= 1'b1;
						total_q   <= total_d;
						offset_q  <= offset_d;
						counter_q <= counter_d;
						if (start) begin
							shader_q <= sub_q.shader_id;
							blend_q  <= sub_q.blend_mode;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sub_q <= sub_data;
		end
		if (commit.valid) begin
			res_q.new_batch          <= start;
			res_q.batch_number       <= counter_d;
			res_q.texture_slot       <= 4'(slot);
			res_q.batch_index_offset <= offset_d;
			res_q.batch_index_total  <= total_d;
		end
	end

endmodule

### rtl/dcb_ram.sv
module dcb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/dcb_slot_table.sv
module dcb_slot_table #(
	parameter int TEXTURE_SLOTS = dcb_pkg::TEXTURE_SLOTS_DEF,
	localparam int SW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [31:0]         handle,
	input  dcb_pkg::commit_t    commit,
	output dcb_pkg::scan_stat_t stat,
	output logic [SW-1:0]       slot
);

	import dcb_pkg::*;

	`include "draw_call_batcher_defines.svh"

	localparam int CW = $clog2(TEXTURE_SLOTS + 1);

	logic [CW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic          busy_q;
	logic          pend_q;
	logic          found_q;
	logic          done_q;
	logic [SW-1:0] pidx_q;
	logic [SW-1:0] fidx_q;
	logic [31:0]   rdata;
	logic          issue;
	logic          hit;
	logic          finish;
	logic          we;
	logic [SW-1:0] waddr;

	// one read issued per cycle while the scan runs, compared in the cycle after it
	assign hit    = busy_q && pend_q && (rdata == handle);
	assign issue  = busy_q && !hit && (idx_q < used_q);
	assign finish = busy_q && !issue;

	// new handle goes to slot 0 on a fresh batch, else to the next free slot
	assign we    = commit.valid && (commit.clear || !found_q);
	assign waddr = commit.clear ? '0 : used_q[SW-1:0];
	assign slot  = commit.clear ? '0 : (found_q ? fidx_q : used_q[SW-1:0]);

	assign stat.done  = done_q;
	assign stat.found = found_q;
	assign stat.full  = (used_q == CW'(TEXTURE_SLOTS));

	dcb_ram #(
		.WIDTH(32),
		.DEPTH(TEXTURE_SLOTS)
	) u_handles (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(handle),
		.re   (issue),
		.raddr(idx_q[SW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			idx_q   <= '0;
			used_q  <= '0;
		end else begin
			done_q <= finish;
			if (go) begin
				busy_q <= 1'b1;
				pend_q <= 1'b0;
				idx_q  <= '0;
			end else if (busy_q) begin
				pend_q <= issue;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (finish) begin
					busy_q  <= 1'b0;
					found_q <= hit;
				end
			end
			if (commit.valid) begin
				if (commit.clear) begin
					used_q <= CW'(1);
				end else if (!found_q) begin
					used_q <= used_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			pidx_q <= idx_q[SW-1:0];
			if (finish) begin
				fidx_q <= pidx_q;
			end
		end
	end

	`DCB_ASSERT_NOW(a_used_range, 1'b1, used_q <= CW'(TEXTURE_SLOTS), "slot count past table depth")
	`DCB_ASSERT_NOW(a_commit_idle, commit.valid, !busy_q && !go, "commit during slot scan")
	`DCB_ASSERT_NEXT(a_done_once, done_q, !done_q && !busy_q, "scan done repeated")

endmodule

### tb/tb.sv
module tb;
	import dcb_pkg::*;

	// slot table depth of the block as built here
	localparam int NSLOTS = TEXTURE_SLOTS_DEF;
	// generous bound on the whole run
	localparam int CYCLE_LIMIT = 3_000_000;
	// cycles the receiver holds off during the backpressure phase
	localparam int HOLD_CYCLES = 300;
	// texture handles in rotation for the random scenes, more than the table holds
	localparam int POOL_SIZE = 20;

	logic clk;
	logic arst_n;
	logic sub_valid;
	logic sub_stall;
	sub_t sub_data;
	logic res_valid;
	logic res_stall;
	res_t res_data;

	draw_call_batcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sub_valid (sub_valid),
		.sub_stall (sub_stall),
		.sub_data  (sub_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// one row of the directed table; typed rows carry a hand-written result
	typedef struct {
		sub_t sub;
		bit   typed;
		res_t want;
	} dir_row_t;

	// shadow of the batcher state, advanced once per accepted submission
	bit          bopen;
	logic [15:0] bshader;
	logic [3:0]  bblend;
	logic [31:0] bhandles [NSLOTS];
	int unsigned bused;
	logic [31:0] boffset;
	logic [31:0] btotal;
	logic [15:0] bnumber;

	// results still owed by the block, oldest first
	res_t pending_results [$];

	// random scene: the shader, blend mode and textures that most draws share
	logic [15:0] scene_shader;
	logic [3:0]  scene_blend;
	logic [31:0] tex_pool [POOL_SIZE];

	dir_row_t dir_rows [$];

	// idle control shared by the sender and the receiver
	bit no_idle;
	bit long_hold;

	int cyc;
	int err_count;
	int n_accepted;
	int n_results;
	int n_starts;
	int n_full_starts;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d results still owed", cyc,
				pending_results.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	// slot holding the handle in the open batch, NSLOTS if absent
	function automatic int unsigned slot_of(input logic [31:0] handle);
		for (int unsigned k = 0; k < bused && k < NSLOTS; k++) begin
			if (bhandles[k] == handle)
				return k;
		end
		return NSLOTS;
	endfunction

	// batching decision and slot allocation for one submission
	function automatic res_t batch_step(input sub_t s);
		int unsigned slot;
		bit          start;
		bit          table_full;
		res_t        r;
		slot = slot_of(s.texture_handle);
		table_full = (slot == NSLOTS) && (bused >= NSLOTS);
		if (!bopen) begin
			start = 1'b1;
		end else begin
			start = (s.shader_id != bshader) || (s.blend_mode != bblend) ||
				s.uniforms_dirty || table_full;
		end
		if (start) begin
			if (bopen)
				bnumber = bnumber + 16'd1;
			if (bopen && table_full && s.shader_id == bshader && s.blend_mode == bblend &&
				!s.uniforms_dirty)
				n_full_starts++;
			bopen   = 1'b1;
			bshader = s.shader_id;
			bblend  = s.blend_mode;
			boffset = s.base_index;
			btotal  = '0;
			bused   = 0;
			n_starts++;
		end
		btotal = btotal + s.index_count;
		slot = slot_of(s.texture_handle);
		// a free slot always exists here: a full table would have forced a new batch
		if (slot == NSLOTS) begin
			slot = bused;
			bhandles[slot] = s.texture_handle;
			bused++;
		end
		r.new_batch          = start;
		r.batch_number       = bnumber;
		r.texture_slot       = slot[3:0];
		r.batch_index_offset = boffset;
		r.batch_index_total  = btotal;
		return r;
	endfunction

	function automatic dir_row_t row(input logic [15:0] shader, input logic [3:0] blend,
		input logic [31:0] handle, input logic dirty, input logic [31:0] base,
		input logic [31:0] count, input bit typed, input res_t want);
		dir_row_t d;
		d.sub.shader_id      = shader;
		d.sub.blend_mode     = blend;
		d.sub.texture_handle = handle;
		d.sub.uniforms_dirty = dirty;
		d.sub.base_index     = base;
		d.sub.index_count    = count;
		d.typed              = typed;
		d.want               = want;
		return d;
	endfunction

	// append one row to the directed table
	function automatic void add_row(input dir_row_t d);
		dir_rows.insert(dir_rows.size(), d);
	endfunction

	function automatic void refresh_pool();
		for (int k = 0; k < POOL_SIZE; k++)
			tex_pool[k] = $urandom;
		// keep the all-zero and all-one handles in rotation now and then
		if ($urandom_range(0, 3) == 0)
			tex_pool[$urandom_range(0, POOL_SIZE - 1)] = '0;
		if ($urandom_range(0, 3) == 0)
			tex_pool[$urandom_range(0, POOL_SIZE - 1)] = '1;
	endfunction

	// mostly well-formed draws of one scene; some scene changes, dirty flags and noise
	function automatic sub_t random_sub();
		sub_t s;
		int   r;
		r = $urandom_range(0, 99);
		if (r < 5)
			scene_shader = 16'($urandom);
		else if (r < 8)
			scene_blend = 4'($urandom);
		else if (r < 10)
			refresh_pool();
		s.shader_id  = scene_shader;
		s.blend_mode = scene_blend;
		// stray draw from another pass, breaks the batch
		if ($urandom_range(0, 99) < 4) begin
			s.shader_id  = 16'($urandom);
			s.blend_mode = 4'($urandom);
		end
		s.uniforms_dirty = ($urandom_range(0, 99) < 4);
		if ($urandom_range(0, 99) < 85)
			s.texture_handle = tex_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			s.texture_handle = $urandom;
		s.base_index = $urandom;
		case ($urandom_range(0, 3))
			0: s.index_count = $urandom;
			1: s.index_count = 32'hFFFF_FFF0 + $urandom_range(0, 15);
			default: s.index_count = $urandom_range(0, 3000);
		endcase
		return s;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		err_count++;
		if (err_count <= 40)
			$display("tb: result %0d, %s: got %h, want %h", n_results, what, got, want);
	endtask

	// offer one submission; entered and left at a falling edge
	task automatic offer(input sub_t s, input bit typed, input res_t want);
		int   gap;
		res_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			sub_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sub_valid = 1'b1;
		sub_data  = s;
		// payload holds until the block takes it
		do @(posedge clk); while (sub_stall);
		predicted = batch_step(s);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		n_accepted++;
		@(negedge clk);
	endtask

	// sender pause: nothing offered until every owed result is back
	task automatic drain();
		sub_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int run;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				// block fills up behind this and must stall its input
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end
			run = pick_gap();
			if (run > 0) begin
				res_stall = 1'b1;
				repeat (run) @(negedge clk);
			end
			res_stall = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	// result check against the oldest owed transaction
	always @(posedge clk) begin : res_check
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, offset", res_data.batch_index_offset, '0);
			end else begin
				want = pending_results.pop_front();
				if (res_data.new_batch !== want.new_batch)
					report_mismatch("new_batch", 32'(res_data.new_batch), 32'(want.new_batch));
				if (res_data.batch_number !== want.batch_number)
					report_mismatch("batch_number", 32'(res_data.batch_number),
						32'(want.batch_number));
				if (res_data.texture_slot !== want.texture_slot)
					report_mismatch("texture_slot", 32'(res_data.texture_slot),
						32'(want.texture_slot));
				if (res_data.batch_index_offset !== want.batch_index_offset)
					report_mismatch("batch_index_offset", res_data.batch_index_offset,
						want.batch_index_offset);
				if (res_data.batch_index_total !== want.batch_index_total)
					report_mismatch("batch_index_total", res_data.batch_index_total,
						want.batch_index_total);
			end
			n_results++;
		end
	end

	initial begin
		res_t none;
		sub_valid = 1'b0;
		sub_data  = '0;
		arst_n    = 1'b0;
		no_idle   = 1'b0;
		long_hold = 1'b0;
		none      = '0;
		bopen     = 1'b0;
		bshader   = '0;
		bblend    = '0;
		bused     = 0;
		boffset   = '0;
		btotal    = '0;
		bnumber   = '0;
		scene_shader = 16'($urandom);
		scene_blend  = 4'($urandom);
		refresh_pool();

		// first draw after reset opens batch 0 with all-zero fields
		add_row(row(16'h0000, 4'h0, 32'h0, 1'b0, 32'h0, 32'h0,
			1, res_t'{1'b1, 16'd0, 4'd0, 32'h0, 32'h0}));
		// same state joins; largest count, then total wraps back to zero
		add_row(row(16'h0000, 4'h0, 32'h0, 1'b0, 32'h1234, 32'hFFFF_FFFF,
			1, res_t'{1'b0, 16'd0, 4'd0, 32'h0, 32'hFFFF_FFFF}));
		add_row(row(16'h0000, 4'h0, 32'h0, 1'b0, 32'h0, 32'h1,
			1, res_t'{1'b0, 16'd0, 4'd0, 32'h0, 32'h0}));
		// shader and blend at their top values force a new batch
		add_row(row(16'hFFFF, 4'hF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'd5,
			1, res_t'{1'b1, 16'd1, 4'd0, 32'hFFFF_FFFF, 32'd5}));
		// dirty uniforms alone force a new batch
		add_row(row(16'hFFFF, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'd7, 32'd2,
			1, res_t'{1'b1, 16'd2, 4'd0, 32'd7, 32'd2}));
		// blend change alone forces a new batch; dirty is not remembered after it
		add_row(row(16'hFFFF, 4'hA, 32'hFFFF_FFFF, 1'b0, 32'd100, 32'd3,
			1, res_t'{1'b1, 16'd3, 4'd0, 32'd100, 32'd3}));
		add_row(row(16'hFFFF, 4'hA, 32'hAAAA_5555, 1'b0, 32'd9, 32'd4,
			1, res_t'{1'b0, 16'd3, 4'd1, 32'd100, 32'd7}));
		// fill the remaining slots with fresh textures
		for (int k = 2; k < NSLOTS; k++)
			add_row(row(16'hFFFF, 4'hA, 32'h0001_0000 + k, 1'b0, $urandom,
				$urandom_range(0, 50), 0, none));
		// known texture on a full table still joins
		add_row(row(16'hFFFF, 4'hA, 32'hAAAA_5555, 1'b0, 32'd0, 32'd1, 0, none));
		// new texture on a full table opens a new batch at slot 0
		add_row(row(16'hFFFF, 4'hA, 32'h5555_AAAA, 1'b0, 32'h8000_0000, 32'd1,
			1, res_t'{1'b1, 16'd4, 4'd0, 32'h8000_0000, 32'd1}));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_rows[k])
			offer(dir_rows[k].sub, dir_rows[k].typed, dir_rows[k].want);
		drain();

		// random scenes, part one
		repeat (200)
			offer(random_sub(), 0, none);

		// receiver holds off while the sender keeps offering back to back
		long_hold = 1'b1;
		no_idle   = 1'b1;
		repeat (16)
			offer(random_sub(), 0, none);
		no_idle = 1'b0;
		drain();

		// random scenes, part two, with a stretch of no idling in the middle
		repeat (120)
			offer(random_sub(), 0, none);
		no_idle = 1'b1;
		repeat (60)
			offer(random_sub(), 0, none);
		no_idle = 1'b0;
		repeat (100)
			offer(random_sub(), 0, none);
		drain();

		// let any late extra result show up
		repeat (40) @(posedge clk);

		$display("tb: %0d draws accepted, %0d results checked, %0d batch starts",
			n_accepted, n_results, n_starts);
		$display("tb: %0d starts forced by a full slot table", n_full_starts);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/dcb_pkg.sv
rtl/dcb_ram.sv
rtl/dcb_slot_table.sv
rtl/draw_call_batcher.sv
tb/tb.sv
